// File: hdl/gif_lzw_code_packer_macros.svh
// ----------------------------------------------------------------------------
// gif_lzw_code_packer_macros.svh
// Assertion macros shared by the LZW code packer RTL.
// ----------------------------------------------------------------------------
`ifndef GIF_LZW_CODE_PACKER_MACROS_SVH
`define GIF_LZW_CODE_PACKER_MACROS_SVH

// same-cycle implication
`define GLZW_ASSERT_IMP(NAME, CLK, RSTN, ANTE, CONS, MSG) \
    NAME: assert property (@(posedge CLK) disable iff (!RSTN) (ANTE) |-> (CONS)) \
        else $error(MSG);

// next-cycle implication
`define GLZW_ASSERT_NXT(NAME, CLK, RSTN, ANTE, CONS, MSG) \
    NAME: assert property (@(posedge CLK) disable iff (!RSTN) (ANTE) |=> (CONS)) \
        else $error(MSG);

`endif

// File: hdl/glzw_pkg.sv
// ----------------------------------------------------------------------------
// glzw_pkg
// Types, constants and helpers of the GIF LZW code packer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package glzw_pkg;

    localparam int CODE_W        = 12;
    localparam int NEXT_W        = 13;
    localparam int PIX_W         = 8;
    localparam int DEPTH_W       = 4;
    localparam int CWID_W        = 4;
    localparam int KEY_W         = CODE_W + PIX_W;
    localparam int ACC_W         = CODE_W + 7;
    localparam int NCNT_W        = 5;
    localparam int MAX_CODES_DEF = 4096;

    localparam logic [DEPTH_W-1:0] DEPTH_RESET = 4'd8;
    localparam logic [DEPTH_W-1:0] DEPTH_MIN   = 4'd2;
    localparam logic [DEPTH_W-1:0] DEPTH_MAX   = 4'd8;
    localparam logic [CWID_W-1:0]  CWID_MAX    = 4'd12;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PROBE_H,
        ST_PROBE_D,
        ST_MISS,
        ST_FULL_CLR,
        ST_TAIL,
        ST_STOP,
        ST_DRAIN,
        ST_FLUSH
    } state_t;

    function automatic logic [DEPTH_W-1:0] clamp_depth(input logic [DEPTH_W-1:0] d);
        logic [DEPTH_W-1:0] r;
        r = d;
        if (d < DEPTH_MIN) r = DEPTH_MIN;
        if (d > DEPTH_MAX) r = DEPTH_MAX;
        return r;
    endfunction

    function automatic logic [PIX_W-1:0] pix_mask(input logic [DEPTH_W-1:0] d);
        logic [PIX_W:0] full;
        full = (9'd1 << d) - 9'd1;
        return full[PIX_W-1:0];
    endfunction

endpackage

`default_nettype wire

// File: hdl/glzw_ram.sv
// ----------------------------------------------------------------------------
// glzw_ram
// Simple dual-port RAM, one write and one read port, registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module glzw_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic             aclk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// File: hdl/gif_lzw_code_packer.sv
// ----------------------------------------------------------------------------
// gif_lzw_code_packer
// Variable-width LZW encoder for GIF pixel data, codes packed LSB first.
// ----------------------------------------------------------------------------
// One pixel is handled at a time. The string table is a hash of
// (prefix, pixel) with linear probing: a slot RAM maps hash slot to code and
// a code RAM holds {prefix, pixel, slot} per code, which also validates the
// slot, so a dictionary restart needs no clearing pass. A pixel passes
// through an accept step, probe steps (slot RAM read, then code RAM read;
// an empty slot ends the probe after the first) and a closing step. Every
// code sent passes through an emitting step and a drain that pushes each
// full byte and keeps the leftover bits pending, and a full dictionary
// adds the clear code. The last pixel also sends the prefix and stop codes
// and ends with a flush. m_ready stalls hold the drain and the flush.
// color_depth is sampled when an image begins.
`timescale 1ns / 1ps
`default_nettype none

`include "gif_lzw_code_packer_macros.svh"

module gif_lzw_code_packer
    import glzw_pkg::*;
#(
    parameter int MAX_CODES = MAX_CODES_DEF
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_wr_en,
    input  wire logic [DEPTH_W-1:0] cfg_wr_data,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [PIX_W-1:0]   s_pixel,
    input  wire logic               s_last_pixel,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic      [PIX_W-1:0]   m_data_byte,
    output logic                    m_last_byte
);

    localparam int SW  = $clog2(MAX_CODES);
    localparam int DW  = KEY_W + SW;

    state_t state_reg, state_next, ret_reg, ret_next;

    logic [DEPTH_W-1:0] color_depth_reg;
    logic [DEPTH_W-1:0] depth_reg, depth_next;
    logic [NEXT_W-1:0]  next_code_reg, next_code_next;
    logic [CWID_W-1:0]  cwid_reg, cwid_next;
    logic [CODE_W-1:0]  prefix_reg, prefix_next;
    logic               started_reg, started_next;
    logic [7:0]         pend_bits_reg, pend_bits_next;
    logic [2:0]         pend_cnt_reg, pend_cnt_next;
    logic [ACC_W-1:0]   acc_reg, acc_next;
    logic [NCNT_W-1:0]  ncnt_reg, ncnt_next;
    logic [PIX_W-1:0]   pix_reg, pix_next;
    logic               last_reg, last_next;
    logic [SW-1:0]      slot_reg, slot_next;
    logic [CODE_W-1:0]  code_reg, code_next;

    logic               m_valid_reg;
    logic [PIX_W-1:0]   m_data_reg;
    logic               m_last_reg;

    logic               push;
    logic [PIX_W-1:0]   push_data;
    logic               push_last;
    logic               out_free;

    logic               emit;
    logic [CODE_W-1:0]  emit_code;
    logic [CWID_W-1:0]  emit_width;

    logic [DEPTH_W-1:0] in_depth;
    logic [NEXT_W-1:0]  in_degree;
    logic [NEXT_W-1:0]  degree;
    logic [PIX_W-1:0]   pix_in;
    logic [KEY_W-1:0]   key;
    logic [CODE_W-1:0]  hash12;
    logic [SW-1:0]      hash_fold;
    logic [SW-1:0]      hash_slot;
    logic [SW-1:0]      slot_inc;
    logic               in_range;
    logic               dict_full;
    logic               d_slot_eq;
    logic               d_key_eq;

    logic               wr_en;
    logic [CODE_W-1:0]  h_rdata;
    logic [DW-1:0]      d_rdata;

    assign out_free  = !m_valid_reg || m_ready;
    assign in_depth  = clamp_depth(color_depth_reg);
    assign in_degree = NEXT_W'(1) << in_depth;
    assign degree    = NEXT_W'(1) << depth_reg;
    assign pix_in    = s_pixel & pix_mask(started_reg ? depth_reg : in_depth);
    assign key       = {prefix_reg, pix_reg};

    assign hash12    = prefix_reg ^ {pix_in, 4'b0000};
    assign hash_fold = hash12[SW-1:0] ^ SW'(hash12 >> SW);
    assign hash_slot = ({1'b0, hash_fold} >= (SW+1)'(MAX_CODES))
                     ? SW'({1'b0, hash_fold} - (SW+1)'(MAX_CODES)) : hash_fold;
    assign slot_inc  = ({1'b0, slot_reg} == (SW+1)'(MAX_CODES - 1))
                     ? '0 : slot_reg + SW'(1);

    assign in_range  = ({1'b0, h_rdata} >= degree + NEXT_W'(2))
                    && ({1'b0, h_rdata} < next_code_reg);
    assign dict_full = next_code_reg >= NEXT_W'(MAX_CODES);
    assign d_slot_eq = d_rdata[SW-1:0] == slot_reg;
    assign d_key_eq  = d_rdata[DW-1:SW] == key;

    assign wr_en     = (state_reg == ST_MISS) && !dict_full;

    glzw_ram #(.WIDTH(CODE_W), .DEPTH(MAX_CODES)) u_slot_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (slot_reg),
        .wr_data (next_code_reg[CODE_W-1:0]),
        .rd_addr (slot_next),
        .rd_data (h_rdata)
    );

    glzw_ram #(.WIDTH(DW), .DEPTH(MAX_CODES)) u_code_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (next_code_reg[SW-1:0]),
        .wr_data ({key, slot_reg}),
        .rd_addr (h_rdata[SW-1:0]),
        .rd_data (d_rdata)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = started_reg ? ST_PROBE_H : ST_DRAIN;
                end
            end
            ST_PROBE_H:  state_next = in_range ? ST_PROBE_D : ST_MISS;
            ST_PROBE_D: begin
                if (d_slot_eq && d_key_eq) begin
                    state_next = ST_TAIL;
                end else if (d_slot_eq) begin
                    state_next = ST_PROBE_H;
                end else begin
                    state_next = ST_MISS;
                end
            end
            ST_MISS:     state_next = ST_DRAIN;
            ST_FULL_CLR: state_next = ST_DRAIN;
            ST_TAIL:     state_next = last_reg ? ST_DRAIN : ST_IDLE;
            ST_STOP:     state_next = ST_DRAIN;
            ST_DRAIN: begin
                if (ncnt_reg < NCNT_W'(8)) begin
                    state_next = ret_reg;
                end
            end
            ST_FLUSH: begin
                if (pend_cnt_reg == 3'd0 || out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        ret_next       = ret_reg;
        depth_next     = depth_reg;
        next_code_next = next_code_reg;
        cwid_next      = cwid_reg;
        prefix_next    = prefix_reg;
        started_next   = started_reg;
        pend_bits_next = pend_bits_reg;
        pend_cnt_next  = pend_cnt_reg;
        acc_next       = acc_reg;
        ncnt_next      = ncnt_reg;
        pix_next       = pix_reg;
        last_next      = last_reg;
        slot_next      = slot_reg;
        code_next      = code_reg;
        emit           = 1'b0;
        emit_code      = prefix_reg;
        emit_width     = cwid_reg;
        push           = 1'b0;
        push_data      = acc_reg[PIX_W-1:0];
        push_last      = 1'b0;
        s_ready        = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    pix_next  = pix_in;
                    last_next = s_last_pixel;
                    if (!started_reg) begin
                        depth_next     = in_depth;
                        next_code_next = in_degree + NEXT_W'(2);
                        cwid_next      = CWID_W'(in_depth) + CWID_W'(1);
                        emit           = 1'b1;
                        emit_code      = in_degree[CODE_W-1:0];
                        emit_width     = CWID_W'(in_depth) + CWID_W'(1);
                        prefix_next    = CODE_W'(pix_in);
                        started_next   = 1'b1;
                        ret_next       = ST_TAIL;
                    end else begin
                        slot_next = hash_slot;
                    end
                end
            end
            ST_PROBE_H: begin
                code_next = h_rdata;
            end
            ST_PROBE_D: begin
                if (d_slot_eq && d_key_eq) begin
                    prefix_next = code_reg;
                end else if (d_slot_eq) begin
                    slot_next = slot_inc;
                end
            end
            ST_MISS: begin
                emit        = 1'b1;
                prefix_next = CODE_W'(pix_reg);
                if (!dict_full) begin
                    if (cwid_reg < CWID_MAX && next_code_reg == (NEXT_W'(1) << cwid_reg)) begin
                        cwid_next = cwid_reg + CWID_W'(1);
                    end
                    next_code_next = next_code_reg + NEXT_W'(1);
                    ret_next       = ST_TAIL;
                end else begin
                    ret_next = ST_FULL_CLR;
                end
            end
            ST_FULL_CLR: begin
                emit           = 1'b1;
                emit_code      = degree[CODE_W-1:0];
                next_code_next = degree + NEXT_W'(2);
                cwid_next      = CWID_W'(depth_reg) + CWID_W'(1);
                ret_next       = ST_TAIL;
            end
            ST_TAIL: begin
                if (last_reg) begin
                    emit     = 1'b1;
                    ret_next = ST_STOP;
                end
            end
            ST_STOP: begin
                emit      = 1'b1;
                emit_code = degree[CODE_W-1:0] + CODE_W'(1);
                ret_next  = ST_FLUSH;
            end
            ST_DRAIN: begin
                if (ncnt_reg >= NCNT_W'(8)) begin
                    if (out_free) begin
                        push      = 1'b1;
                        push_last = (ret_reg == ST_FLUSH) && (ncnt_reg == NCNT_W'(8));
                        acc_next  = acc_reg >> 8;
                        ncnt_next = ncnt_reg - NCNT_W'(8);
                    end
                end else begin
                    pend_bits_next = acc_reg[7:0];
                    pend_cnt_next  = ncnt_reg[2:0];
                end
            end
            ST_FLUSH: begin
                if (pend_cnt_reg == 3'd0 || out_free) begin
                    push           = pend_cnt_reg != 3'd0;
                    push_data      = pend_bits_reg;
                    push_last      = 1'b1;
                    pend_bits_next = '0;
                    pend_cnt_next  = '0;
                    prefix_next    = '0;
                    started_next   = 1'b0;
                    next_code_next = degree + NEXT_W'(2);
                    cwid_next      = CWID_W'(depth_reg) + CWID_W'(1);
                end
            end
            default: begin
            end
        endcase

        if (emit) begin
            acc_next  = ACC_W'(pend_bits_reg) | (ACC_W'(emit_code) << pend_cnt_reg);
            ncnt_next = NCNT_W'(pend_cnt_reg) + NCNT_W'(emit_width);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            ret_reg         <= ST_IDLE;
            color_depth_reg <= DEPTH_RESET;
            depth_reg       <= DEPTH_RESET;
            next_code_reg   <= (NEXT_W'(1) << DEPTH_RESET) + NEXT_W'(2);
            cwid_reg        <= CWID_W'(DEPTH_RESET) + CWID_W'(1);
            prefix_reg      <= '0;
            started_reg     <= 1'b0;
            pend_bits_reg   <= '0;
            pend_cnt_reg    <= '0;
            ncnt_reg        <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg     <= state_next;
            ret_reg       <= ret_next;
            depth_reg     <= depth_next;
            next_code_reg <= next_code_next;
            cwid_reg      <= cwid_next;
            prefix_reg    <= prefix_next;
            started_reg   <= started_next;
            pend_bits_reg <= pend_bits_next;
            pend_cnt_reg  <= pend_cnt_next;
            ncnt_reg      <= ncnt_next;
            if (cfg_wr_en) begin
                color_depth_reg <= cfg_wr_data;
            end
            if (push) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg  <= acc_next;
        pix_reg  <= pix_next;
        last_reg <= last_next;
        slot_reg <= slot_next;
        code_reg <= code_next;
        if (push) begin
            m_data_reg <= push_data;
            m_last_reg <= push_last;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_data_byte = m_data_reg;
    assign m_last_byte = m_last_reg;

    `GLZW_ASSERT_IMP(a_push_free, aclk, aresetn, push, out_free, "push into full output")
    `GLZW_ASSERT_IMP(a_code_bound, aclk, aresetn, 1'b1, next_code_reg <= NEXT_W'(MAX_CODES), "code range")
    `GLZW_ASSERT_NXT(a_one_item, aclk, aresetn, s_valid && s_ready, !s_ready, "pixel taken while busy")
    `GLZW_ASSERT_IMP(a_drain_cnt, aclk, aresetn, state_reg == ST_DRAIN, ncnt_reg <= NCNT_W'(ACC_W), "bit count")

endmodule

`default_nettype wire
